// ----- sv/tagged_line_assembler_top_macros.svh -----
// Assertion macros shared by the tagged line assembler modules.
// Included by the controller and the datapath; needs no other file.
`ifndef TAGGED_LINE_ASSEMBLER_TOP_MACROS_SVH
`define TAGGED_LINE_ASSEMBLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tla_pkg.sv -----
// Shared types and constants of the tagged line assembler.
// Used by tla_ctrl, tla_dp and tagged_line_assembler_top; depends on nothing.
`default_nettype none

package tla_pkg;

  // Input word: one store or read request
  typedef struct packed {
    logic       action;
    logic [3:0] channel;
    logic [7:0] data_byte;
    logic [3:0] read_row;
    logic [5:0] read_column;
  } in_word_t;

  // Output word: one result per request
  typedef struct packed {
    logic [7:0] read_char;
    logic [3:0] write_row;
    logic [5:0] write_column;
    logic       row_closed;
  } out_word_t;

  // Request codes
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Byte that closes a row
  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // Configuration register map (word index) and reset value
  localparam logic       CFG_IDX_TAG_OFFSET = 1'b0;
  localparam logic [7:0] TAG_OFFSET_RESET   = 8'd48;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_STORE,
    ST_READ,
    ST_WIPE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch_item;
    logic clear_step;
    logic wipe_step;
    logic wr_tag;
    logic wr_data;
    logic rd_issue;
    logic rd_load;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_read;
    logic col_zero;
    logic closes;
    logic out_free;
    logic clear_done;
    logic wipe_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- sv/tla_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used by tla_dp for the line store.
`default_nettype none

module tla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/tla_ctrl.sv -----
// Controller of the tagged line assembler: sequences clear, store, read and row wipe.
// Depends on tla_pkg and tagged_line_assembler_top_macros.svh; drives tla_dp.
`default_nettype none
`include "tagged_line_assembler_top_macros.svh"

module tla_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire tla_pkg::dp_sts_t  sts_i,
  output tla_pkg::dp_cmd_t       cmd_o
);

  tla_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tla_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tla_pkg::ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = tla_pkg::ST_IDLE;
        end
      end
      tla_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = tla_pkg::ST_EXEC;
        end
      end
      tla_pkg::ST_EXEC: begin
        if (sts_i.is_read) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = tla_pkg::ST_READ;
        end else if (sts_i.col_zero) begin
          // tag byte goes first, then the data byte
          cmd_o.wr_tag = 1'b1;
          state_d      = tla_pkg::ST_STORE;
        end else if (sts_i.out_free) begin
          cmd_o.wr_data = 1'b1;
          state_d       = sts_i.closes ? tla_pkg::ST_WIPE : tla_pkg::ST_IDLE;
        end else begin
          state_d = tla_pkg::ST_STORE;
        end
      end
      tla_pkg::ST_STORE: begin
        if (sts_i.out_free) begin
          cmd_o.wr_data = 1'b1;
          state_d       = sts_i.closes ? tla_pkg::ST_WIPE : tla_pkg::ST_IDLE;
        end
      end
      tla_pkg::ST_READ: begin
        if (sts_i.out_free) begin
          cmd_o.rd_load = 1'b1;
          state_d       = tla_pkg::ST_IDLE;
        end
      end
      tla_pkg::ST_WIPE: begin
        cmd_o.wipe_step = 1'b1;
        if (sts_i.wipe_done) begin
          state_d = tla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tla_pkg::ST_CLEAR;
      end
    endcase
  end

  // At most one memory write per cycle
  `TLA_ASSERT_IMPLY(a_one_write, clk_i, rst_ni, 1'b1, $onehot0({cmd_o.clear_step, cmd_o.wipe_step, cmd_o.wr_tag, cmd_o.wr_data}), "two memory writes in one cycle")

endmodule

`default_nettype wire

// ----- sv/tla_dp.sv -----
// Datapath of the tagged line assembler: fill position, line store, sweep counter, output word.
// Depends on tla_pkg, tla_ram and tagged_line_assembler_top_macros.svh.
`default_nettype none
`include "tagged_line_assembler_top_macros.svh"

module tla_dp #(
  parameter int ROWS    = 16,
  parameter int COLUMNS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tla_pkg::in_word_t in_data_i,
  input  wire logic [7:0]        tag_offset_i,
  input  wire tla_pkg::dp_cmd_t  cmd_i,
  output tla_pkg::dp_sts_t       sts_o,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output tla_pkg::out_word_t     out_data_o
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [CW:0]   CLOSE_COL = (CW+1)'(COLUMNS - 1);

  tla_pkg::in_word_t  item_q;
  tla_pkg::out_word_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [RW-1:0]      fill_row_q, fill_row_d;
  logic [CW-1:0]      fill_col_q, fill_col_d;
  logic [AW-1:0]      sweep_q, sweep_d;

  logic [CW:0]        col_inc;
  logic               closes;
  logic [RW-1:0]      row_next;
  logic [RW-1:0]      new_row;
  logic [CW-1:0]      new_col;
  logic [8:0]         rrow_ext, rcol_ext;
  logic               rd_in_range;
  logic [8:0]         cur_row_ext, cur_col_ext, new_row_ext, new_col_ext;
  logic               out_free;
  logic               clear_done, wipe_done;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [7:0]         ram_rdata;

  // Hold the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      item_q <= in_data_i;
    end
  end

  // Next fill position for a data byte
  always_comb begin
    col_inc  = {1'b0, fill_col_q} + (CW+1)'(1);
    closes   = (item_q.data_byte == tla_pkg::NEWLINE_BYTE) || (col_inc >= CLOSE_COL);
    row_next = (fill_row_q == LAST_ROW) ? '0 : fill_row_q + RW'(1);
    new_row  = closes ? row_next : fill_row_q;
    new_col  = closes ? '0 : col_inc[CW-1:0];
  end

  // Read position and range check
  always_comb begin
    rrow_ext    = 9'(item_q.read_row);
    rcol_ext    = 9'(item_q.read_column);
    rd_in_range = (rrow_ext < 9'(ROWS)) && (rcol_ext < 9'(COLUMNS));
    ram_raddr   = {rrow_ext[RW-1:0], rcol_ext[CW-1:0]};
  end

  // Sweep completion
  assign clear_done = &sweep_q;
  assign wipe_done  = (sweep_q[CW-1:0] == LAST_COL);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Memory write port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {fill_row_q, fill_col_q};
    ram_wdata = item_q.data_byte;
    if (cmd_i.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
      ram_wdata = '0;
    end else if (cmd_i.wipe_step) begin
      ram_we    = 1'b1;
      ram_waddr = {fill_row_q, sweep_q[CW-1:0]};
      ram_wdata = '0;
    end else if (cmd_i.wr_tag) begin
      ram_we    = 1'b1;
      ram_waddr = {fill_row_q, {CW{1'b0}}};
      ram_wdata = {4'd0, item_q.channel} + tag_offset_i;
    end else if (cmd_i.wr_data) begin
      ram_we    = 1'b1;
    end
  end

  tla_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Advance fill position and sweep counter
  always_comb begin
    fill_row_d = fill_row_q;
    fill_col_d = fill_col_q;
    sweep_d    = sweep_q;
    if (cmd_i.wr_tag) begin
      fill_col_d = CW'(1);
    end
    if (cmd_i.wr_data) begin
      fill_row_d = new_row;
      fill_col_d = new_col;
    end
    if (cmd_i.clear_step) begin
      sweep_d = clear_done ? '0 : sweep_q + AW'(1);
    end
    if (cmd_i.wipe_step) begin
      sweep_d = wipe_done ? '0 : sweep_q + AW'(1);
    end
  end

  // Build the output word
  always_comb begin
    cur_row_ext = 9'(fill_row_q);
    cur_col_ext = 9'(fill_col_q);
    new_row_ext = 9'(new_row);
    new_col_ext = 9'(new_col);
    out_d       = out_q;
    out_valid_d = out_stall_i ? out_valid_q : 1'b0;
    if (cmd_i.rd_load) begin
      out_d.read_char    = rd_in_range ? ram_rdata : 8'd0;
      out_d.write_row    = cur_row_ext[3:0];
      out_d.write_column = cur_col_ext[5:0];
      out_d.row_closed   = 1'b0;
      out_valid_d        = 1'b1;
    end else if (cmd_i.wr_data) begin
      out_d.read_char    = 8'd0;
      out_d.write_row    = new_row_ext[3:0];
      out_d.write_column = new_col_ext[5:0];
      out_d.row_closed   = closes;
      out_valid_d        = 1'b1;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_row_q  <= '0;
      fill_col_q  <= '0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_row_q  <= fill_row_d;
      fill_col_q  <= fill_col_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o            = '0;
    sts_o.is_read    = (item_q.action == tla_pkg::ACT_READ);
    sts_o.col_zero   = (fill_col_q == '0);
    sts_o.closes     = closes;
    sts_o.out_free   = out_free;
    sts_o.clear_done = clear_done;
    sts_o.wipe_done  = wipe_done;
  end

  `TLA_ASSERT_IMPLY(a_load_free, clk_i, rst_ni, cmd_i.wr_data || cmd_i.rd_load, out_free, "result loaded over a word not yet taken")
  `TLA_ASSERT_IMPLY(a_col_range, clk_i, rst_ni, 1'b1, fill_col_q < LAST_COL, "fill column reached the terminator slot")
  `TLA_ASSERT_IMPLY(a_row_range, clk_i, rst_ni, 1'b1, 9'(fill_row_q) < 9'(ROWS), "fill row outside the ring")
  `TLA_ASSERT_NEXT(a_close_wrap, clk_i, rst_ni, cmd_i.wr_data && closes, (fill_col_q == '0) && (fill_row_q == $past(row_next)), "closed row did not move to the next row")

endmodule

`default_nettype wire

// ----- sv/tagged_line_assembler_top.sv -----
// Tagged line assembler: packs channel-tagged received bytes into a ring of ROWS text rows of
// COLUMNS bytes and serves single-byte reads of the store. A store word at column zero first
// writes the tag byte (channel + tag_offset, mod 256) and then the data byte; a newline, or
// reaching the last column, closes the row, which moves to the next row and clears it. Each
// word returns one result word. A store that starts a row writes the tag byte and then the data
// byte, as the single memory write port takes them one after the other; a read issues the memory
// read and then loads the registered read data into the result. A store or read waits while the
// last result word is not yet taken. Clearing the next row after a close runs one byte per cycle,
// and no word is accepted until it ends. After reset the whole store is cleared, during which no
// word is accepted; write the tag_offset register (byte address 0, reset 48) on the APB port only
// while no word is in flight.
// Depends on tla_pkg, tla_ctrl, tla_dp and tla_ram.
`default_nettype none

module tagged_line_assembler_top #(
  parameter int ROWS    = 16,
  parameter int COLUMNS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tla_pkg::in_word_t  in_data_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tla_pkg::out_word_t      out_data_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  tla_pkg::dp_cmd_t cmd;
  tla_pkg::dp_sts_t sts;
  logic [7:0]       tag_offset_q, tag_offset_d;
  logic             sel_tag;

  // Register decode
  assign sel_tag = (paddr[2] == tla_pkg::CFG_IDX_TAG_OFFSET);
  assign pready  = 1'b1;
  assign prdata  = sel_tag ? {24'd0, tag_offset_q} : 32'd0;

  always_comb begin
    tag_offset_d = tag_offset_q;
    if (psel && penable && pwrite && sel_tag) begin
      tag_offset_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_offset_q <= tla_pkg::TAG_OFFSET_RESET;
    end else begin
      tag_offset_q <= tag_offset_d;
    end
  end

  tla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tla_dp #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .tag_offset_i (tag_offset_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ----- sim/tla_line_checker.sv -----
// Scoreboard for the tagged line assembler: watches both word channels and the APB port.
// Keeps its own copy of the row store, predicts every result word and compares it.
// Depends on tla_pkg.
module tla_line_checker import tla_pkg::*; #(
  parameter int ROWS    = 16,
  parameter int COLUMNS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Shadow copy of the row ring and fill position
  logic [7:0]  line_text [ROWS][COLUMNS];
  int unsigned fill_row;
  int unsigned fill_col;
  logic [7:0]  tag_offset;

  out_word_t   due_results[$];
  int unsigned n_mismatch = 0;

  assign fail_count_o = n_mismatch;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_mismatch++;
  endtask

  // Advance to the next row of the ring and blank it
  function automatic void open_next_row();
    fill_col = 0;
    fill_row = (fill_row + 1 >= ROWS) ? 0 : fill_row + 1;
    for (int c = 0; c < COLUMNS; c++) line_text[fill_row][c] = 8'h00;
  endfunction

  // Apply one request word to the shadow store and return the result it should give
  function automatic out_word_t assemble_word(input in_word_t w);
    out_word_t r;
    r = '0;
    if (w.action == ACT_READ) begin
      if (w.read_row < ROWS && w.read_column < COLUMNS)
        r.read_char = line_text[w.read_row][w.read_column];
    end else begin
      // tag byte goes first when a row is opened
      if (fill_col == 0) begin
        line_text[fill_row][0] = 8'(w.channel + tag_offset);
        fill_col = 1;
      end
      line_text[fill_row][fill_col] = w.data_byte;
      if (w.data_byte == NEWLINE_BYTE) begin
        open_next_row();
        r.row_closed = 1'b1;
      end else begin
        fill_col++;
        // keep the last column free as terminator
        if (fill_col >= COLUMNS - 1) begin
          open_next_row();
          r.row_closed = 1'b1;
        end
      end
    end
    r.write_row    = 4'(fill_row);
    r.write_column = 6'(fill_col);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++)
        for (int c = 0; c < COLUMNS; c++) line_text[r][c] = 8'h00;
      fill_row   = 0;
      fill_col   = 0;
      tag_offset = TAG_OFFSET_RESET;
      due_results.delete();
      pending_o <= 0;
    end else begin
      // track register writes and check read-back
      if (psel && penable && pready && paddr[1:0] == 2'b00 &&
          paddr[2] == CFG_IDX_TAG_OFFSET) begin
        if (pwrite) begin
          tag_offset = pwdata[7:0];
        end else if (prdata[7:0] !== tag_offset) begin
          report_mismatch($sformatf("tag_offset read %0h, expected %0h",
                                    prdata[7:0], tag_offset));
        end
      end

      // compare each result word with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_mismatch("result word with no request outstanding");
        end else begin
          out_word_t want;
          want = due_results.pop_front();
          if (out_data_i.read_char !== want.read_char)
            report_mismatch($sformatf("read_char %0h, expected %0h",
                                      out_data_i.read_char, want.read_char));
          if (out_data_i.write_row !== want.write_row)
            report_mismatch($sformatf("write_row %0d, expected %0d",
                                      out_data_i.write_row, want.write_row));
          if (out_data_i.write_column !== want.write_column)
            report_mismatch($sformatf("write_column %0d, expected %0d",
                                      out_data_i.write_column, want.write_column));
          if (out_data_i.row_closed !== want.row_closed)
            report_mismatch($sformatf("row_closed %0b, expected %0b",
                                      out_data_i.row_closed, want.row_closed));
        end
      end

      // predict the result of each accepted request word
      if (in_valid_i && !in_stall_i) due_results.push_back(assemble_word(in_data_i));

      pending_o <= due_results.size();
    end
  end

endmodule

// ----- sim/tb_tagged_line_assembler_top.sv -----
// Testbench top for tagged_line_assembler_top: clock, reset, request and APB stimulus,
// receiver stalls, watchdog and verdict. Prediction and checking sit in tla_line_checker.
// Depends on tla_pkg, tla_line_checker and the assembler RTL.
module tb_tagged_line_assembler_top;
  import tla_pkg::*;

  localparam int ROWS           = 16;
  localparam int COLUMNS        = 64;
  localparam int CLK_PERIOD     = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = COLUMNS + 16;

  localparam logic [2:0] TAG_OFFSET_ADDR = {CFG_IDX_TAG_OFFSET, 2'b00};
  localparam logic [2:0] SPARE_ADDR      = {~CFG_IDX_TAG_OFFSET, 2'b00};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_word_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles  = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct   = 0;
  bit          hold_armed    = 1'b0;
  bit          hold_spent    = 1'b0;
  int unsigned hold_left     = 0;

  // current well-formed line being sent
  int unsigned line_left = 0;
  logic [3:0]  line_chan = '0;

  tagged_line_assembler_top #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tla_line_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Receiver: random stalls, plus one long hold-off when armed
  always @(posedge clk_i) begin
    if (hold_armed && !hold_spent) begin
      hold_spent  <= 1'b1;
      hold_left   <= LONG_HOLD;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one request word and hold it until accepted
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic in_word_t read_word(input int unsigned row, input int unsigned col);
    in_word_t w;
    w.action      = ACT_READ;
    w.channel     = 4'($urandom_range(15));
    w.data_byte   = 8'($urandom_range(255));
    w.read_row    = 4'(row);
    w.read_column = 6'(col);
    return w;
  endfunction

  function automatic in_word_t store_word(input logic [3:0] chan, input logic [7:0] data);
    in_word_t w;
    w.action      = ACT_STORE;
    w.channel     = chan;
    w.data_byte   = data;
    w.read_row    = 4'($urandom_range(15));
    w.read_column = 6'($urandom_range(63));
    return w;
  endfunction

  // Mostly newline-terminated lines of random length, mixed with reads and noise
  function automatic in_word_t next_traffic_word();
    int unsigned pick;
    logic [7:0]  data;
    pick = $urandom_range(99);
    if (pick < 10) begin
      next_traffic_word = read_word($urandom_range(15), $urandom_range(63));
      next_traffic_word.action = 1'($urandom_range(1));
    end else if (pick < 30) begin
      next_traffic_word = read_word($urandom_range(15), $urandom_range(63));
    end else begin
      if (line_left == 0) begin
        line_left = $urandom_range(1, 72);
        line_chan = 4'($urandom_range(15));
      end
      line_left--;
      data = 8'($urandom_range(255));
      if (data == NEWLINE_BYTE) data = 8'h20;
      if (line_left == 0) data = NEWLINE_BYTE;
      next_traffic_word = store_word(line_chan, data);
    end
  endfunction

  task automatic run_traffic(input int unsigned n_words);
    for (int i = 0; i < n_words; i++) send_word(next_traffic_word());
    in_valid_i <= 1'b0;
  endtask

  // Wait for every result, let a row wipe finish, then set the tag offset
  task automatic drain_and_set_tag(input logic [7:0] tag);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_access(1'b1, TAG_OFFSET_ADDR, {24'h0, tag});
    apb_access(1'b0, TAG_OFFSET_ADDR, '0);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // check the reset value of the tag offset
    apb_access(1'b0, TAG_OFFSET_ADDR, '0);

    // Directed: reads of a fresh store, short rows, tag with reset offset
    send_word(read_word(0, 0));
    send_word(read_word(ROWS - 1, COLUMNS - 1));
    send_word(store_word(4'd0, 8'h00));
    send_word(store_word(4'd15, 8'hFF));
    send_word(store_word(4'd3, NEWLINE_BYTE));
    send_word(read_word(0, 0));
    send_word(read_word(0, 2));
    send_word(read_word(0, 3));
    send_word(store_word(4'd9, NEWLINE_BYTE));
    send_word(read_word(1, 0));
    send_word(read_word(1, 1));
    send_word(read_word(2, 0));
    in_valid_i <= 1'b0;

    // Directed: tag wraps past 255
    drain_and_set_tag(8'hFF);
    send_word(store_word(4'd15, 8'h41));
    send_word(store_word(4'd0, 8'h80));
    send_word(read_word(2, 0));
    send_word(read_word(2, 1));
    send_word(read_word(2, 2));
    send_word(read_word(2, COLUMNS - 1));
    send_word(store_word(4'd1, NEWLINE_BYTE));
    in_valid_i <= 1'b0;

    // write to an unmapped register must leave the tag offset alone
    drain_and_set_tag(8'hFF);
    apb_access(1'b1, SPARE_ADDR, 32'h0000_00A5);
    apb_access(1'b0, TAG_OFFSET_ADDR, '0);

    // Random: sender idles lightly, receiver heavily
    drain_and_set_tag(8'h00);
    sender_idle_pct = 27;
    recv_idle_pct  <= 67;
    run_traffic(360);

    // Random: the other way round, with a full drain halfway
    drain_and_set_tag(8'($urandom_range(1, 254)));
    sender_idle_pct = 67;
    recv_idle_pct  <= 27;
    run_traffic(180);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    run_traffic(180);

    // Random: no idling; receiver holds off long enough to back up the input
    drain_and_set_tag(8'd200);
    sender_idle_pct = 0;
    recv_idle_pct  <= 0;
    hold_armed     <= 1'b1;
    run_traffic(380);

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/tla_pkg.sv
sv/tla_ram.sv
sv/tla_ctrl.sv
sv/tla_dp.sv
sv/tagged_line_assembler_top.sv
sim/tla_line_checker.sv
sim/tb_tagged_line_assembler_top.sv
